// ===== hw/rtl/espt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espt_pkg
// Shared widths, constants and the queued request type for the event scalar
// transverse-momentum sum block.
// ----------------------------------------------------------------------------
package espt_pkg;

    localparam int MOMENTUM_BITS = 24;
    localparam int ENERGY_BITS   = MOMENTUM_BITS - 1;
    localparam int CODE_BITS     = 25;
    localparam int SUM_BITS      = 32;

    localparam int MAG_BITS      = MOMENTUM_BITS;
    localparam int RAD_BITS      = 2 * MAG_BITS;
    localparam int ROOT_BITS     = MAG_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);
    localparam int ADD_BITS      = ((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS) + 1;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_BITS-1:0] HIGGS_CODE = CODE_BITS'(25);
    localparam logic [SUM_BITS-1:0]  SUM_MAX    = {SUM_BITS{1'b1}};

    // Classified request: two magnitudes and how to combine their squares.
    typedef struct packed {
        logic [MAG_BITS-1:0] op_a;
        logic [MAG_BITS-1:0] op_b;
        logic                is_diff;
        logic                has_particle;
        logic                last;
    } espt_item_t;

endpackage

// ===== hw/rtl/event_scalar_pt_sum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_scalar_pt_sum_top
// Event scalar transverse-momentum sum (HT) with saturation flag.
// ----------------------------------------------------------------------------
// One request per particle; the request marked last returns the event sum
// floor(sqrt(px^2+py^2)) summed over the event (or, with ht_mode set, the
// transverse mass floor(sqrt(E^2-pz^2)) for code 25, clamped at zero), as
// an unsigned integer, saturating at all ones. A request with a particle
// passes through the back end in order: dequeue, square, form the radicand,
// bit-serial square root and accumulate; a request without a particle goes
// from dequeue straight to accumulate. A two-entry queue and an input stage
// let the front keep taking requests while the back is busy, and a result
// register lets the back continue with the next event's requests while a
// result waits to be taken.
module event_scalar_pt_sum_top
    import espt_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [MOMENTUM_BITS-1:0] mom_x,
    input  logic signed [MOMENTUM_BITS-1:0] mom_y,
    input  logic signed [MOMENTUM_BITS-1:0] mom_z,
    input  logic        [ENERGY_BITS-1:0]   energy,
    input  logic signed [CODE_BITS-1:0]     particle_code,
    input  logic                            has_particle,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic        [SUM_BITS-1:0]      ht_sum,
    output logic                            sum_saturated
);

    logic       ht_mode_reg;
    logic       push;
    espt_item_t push_item;
    logic       queue_full;
    logic       pop;
    espt_item_t pop_item;
    logic       queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ht_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            ht_mode_reg <= cfg_wr_data;
    end

    espt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ht_mode       (ht_mode_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mom_x         (mom_x),
        .mom_y         (mom_y),
        .mom_z         (mom_z),
        .energy        (energy),
        .particle_code (particle_code),
        .has_particle  (has_particle),
        .last          (last),
        .push          (push),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    espt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    espt_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_item      (pop_item),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ht_sum        (ht_sum),
        .sum_saturated (sum_saturated)
    );

endmodule

// ===== hw/rtl/espt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espt_front
// Accepts requests, takes component magnitudes and picks the operand pair
// (pt or Higgs transverse mass), then hands the result to the queue.
// ----------------------------------------------------------------------------
module espt_front
    import espt_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ht_mode,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [MOMENTUM_BITS-1:0] mom_x,
    input  logic signed [MOMENTUM_BITS-1:0] mom_y,
    input  logic signed [MOMENTUM_BITS-1:0] mom_z,
    input  logic        [ENERGY_BITS-1:0]   energy,
    input  logic signed [CODE_BITS-1:0]     particle_code,
    input  logic                            has_particle,
    input  logic                            last,
    output logic                            push,
    output espt_item_t                      push_item,
    input  logic                            queue_full
);

    logic       valid_reg;
    logic       valid_next;
    espt_item_t item_reg;
    espt_item_t item_next;
    logic       accept;
    logic       is_higgs;

    function automatic logic [MAG_BITS-1:0] magnitude(input logic [MOMENTUM_BITS-1:0] v);
        logic [MAG_BITS-1:0] r;
        if (v[MOMENTUM_BITS-1])
            r = MAG_BITS'(~v + 1'b1);
        else
            r = MAG_BITS'(v);
        return r;
    endfunction

    assign push     = valid_reg && !queue_full;
    assign in_stall = valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign is_higgs = ht_mode && (particle_code == HIGGS_CODE);

    always_comb
    begin
        item_next = item_reg;
        valid_next = valid_reg && !push;
        if (accept)
        begin
            valid_next             = 1'b1;
            item_next.is_diff      = is_higgs;
            item_next.has_particle = has_particle;
            item_next.last         = last;
            if (is_higgs)
            begin
                item_next.op_a = MAG_BITS'(energy);
                item_next.op_b = magnitude(mom_z);
            end
            else
            begin
                item_next.op_a = magnitude(mom_x);
                item_next.op_b = magnitude(mom_y);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            item_reg  <= item_next;
        end
    end

    assign push_item = item_reg;

endmodule

// ===== hw/rtl/espt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espt_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module espt_queue
    import espt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  espt_item_t push_item,
    output logic       full,
    input  logic       pop,
    output espt_item_t pop_item,
    output logic       empty
);

    espt_item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    function automatic logic [QUEUE_PTR_BITS-1:0] bump(input logic [QUEUE_PTR_BITS-1:0] p);
        logic [QUEUE_PTR_BITS-1:0] r;
        if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign full     = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (push && !full) ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = (pop && !empty) ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if ((push && !full) && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/espt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espt_back
// Squares the operands, forms the radicand, runs a one-bit-per-cycle integer
// square root, accumulates with saturation and emits the sum on event close.
// ----------------------------------------------------------------------------
module espt_back
    import espt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  espt_item_t          pop_item,
    input  logic                queue_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SUM_BITS-1:0] ht_sum,
    output logic                sum_saturated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_RADICAND,
        S_ROOT,
        S_ACCUM
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    espt_item_t                 item_reg;
    espt_item_t                 item_next;
    logic [RAD_BITS-1:0]        a_sq_reg;
    logic [RAD_BITS-1:0]        a_sq_next;
    logic [RAD_BITS-1:0]        b_sq_reg;
    logic [RAD_BITS-1:0]        b_sq_next;
    logic [RAD_BITS-1:0]        rad_reg;
    logic [RAD_BITS-1:0]        rad_next;
    logic [ROOT_BITS-1:0]       rem_reg;
    logic [ROOT_BITS-1:0]       rem_next;
    logic [ROOT_BITS-1:0]       root_reg;
    logic [ROOT_BITS-1:0]       root_next;
    logic [ROOT_CNT_BITS-1:0]   cnt_reg;
    logic [ROOT_CNT_BITS-1:0]   cnt_next;
    logic [SUM_BITS-1:0]        sum_reg;
    logic [SUM_BITS-1:0]        sum_next;
    logic                       sat_reg;
    logic                       sat_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SUM_BITS-1:0]        ht_sum_reg;
    logic [SUM_BITS-1:0]        ht_sum_next;
    logic                       out_sat_reg;
    logic                       out_sat_next;

    logic [ROOT_BITS+1:0]       rem_shift;
    logic [ROOT_BITS+1:0]       trial;
    logic [ROOT_BITS+1:0]       rem_diff;
    logic [ROOT_BITS-1:0]       term;
    logic [ADD_BITS-1:0]        add_sum;
    logic [SUM_BITS-1:0]        acc_sum;
    logic                       acc_sat;
    logic                       out_full;

    assign rem_shift = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;

    assign term    = item_reg.has_particle ? root_reg : '0;
    assign add_sum = ADD_BITS'(sum_reg) + ADD_BITS'(term);
    assign acc_sat = (add_sum >= ADD_BITS'(SUM_MAX));
    assign acc_sum = acc_sat ? SUM_MAX : add_sum[SUM_BITS-1:0];

    assign out_full = out_valid_reg && out_stall;
    assign pop      = (state_reg == S_IDLE) && !queue_empty;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        a_sq_next      = a_sq_reg;
        b_sq_next      = b_sq_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        out_valid_next = out_full;
        ht_sum_next    = ht_sum_reg;
        out_sat_next   = out_sat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    item_next  = pop_item;
                    root_next  = '0;
                    state_next = pop_item.has_particle ? S_SQUARE : S_ACCUM;
                end
            end
            S_SQUARE:
            begin
                a_sq_next  = item_reg.op_a * item_reg.op_a;
                b_sq_next  = item_reg.op_b * item_reg.op_b;
                state_next = S_RADICAND;
            end
            S_RADICAND:
            begin
                if (!item_reg.is_diff)
                    rad_next = a_sq_reg + b_sq_reg;
                else if (a_sq_reg > b_sq_reg)
                    rad_next = a_sq_reg - b_sq_reg;
                else
                    rad_next = '0;
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = ROOT_CNT_BITS'(ROOT_BITS - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_diff[ROOT_BITS-1:0];
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[ROOT_BITS-1:0];
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (!item_reg.last)
                begin
                    sum_next   = acc_sum;
                    sat_next   = sat_reg | acc_sat;
                    state_next = S_IDLE;
                end
                else if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    ht_sum_next    = acc_sum;
                    out_sat_next   = sat_reg | acc_sat;
                    sum_next       = '0;
                    sat_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            a_sq_reg      <= '0;
            b_sq_reg      <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ht_sum_reg    <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            a_sq_reg      <= a_sq_next;
            b_sq_reg      <= b_sq_next;
            rad_reg       <= rad_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            ht_sum_reg    <= ht_sum_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ht_sum        = ht_sum_reg;
    assign sum_saturated = out_sat_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for event_scalar_pt_sum_top.
// ----------------------------------------------------------------------------
// Queued particle requests are driven in bursts with random gaps. An in-bench
// HT predictor folds each accepted request into its own event sum. Every
// closed event is compared field by field at the output, which stalls on a
// changing pattern and twice holds off long enough to back up the input.
// The run covers both ht_mode settings, directed corner events, one event
// that drives the sum exactly to saturation, and random events.
// ----------------------------------------------------------------------------
module testbench;
    import espt_pkg::*;

    localparam int    SETTLE_CYCLES = 40;
    localparam int    HOLD_CYCLES   = 1200;
    localparam int    SAT_ITEMS     = 362;
    localparam int    RANDOM_ITEMS  = 220;
    localparam longint TIMEOUT_NS   = 1000000;

    localparam logic signed [MOMENTUM_BITS-1:0] MOM_MAX = {1'b0, {(MOMENTUM_BITS-1){1'b1}}};
    localparam logic signed [MOMENTUM_BITS-1:0] MOM_MIN = {1'b1, {(MOMENTUM_BITS-1){1'b0}}};
    localparam logic [ENERGY_BITS-1:0]          EN_MAX  = {ENERGY_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] ANTI_HIGGS  = -HIGGS_CODE;
    localparam logic [CODE_BITS-1:0] HIGGS_ALIAS = CODE_BITS'(HIGGS_CODE | (1 << (CODE_BITS - 1)));

    typedef struct {
        logic signed [MOMENTUM_BITS-1:0] px;
        logic signed [MOMENTUM_BITS-1:0] py;
        logic signed [MOMENTUM_BITS-1:0] pz;
        logic        [ENERGY_BITS-1:0]   en;
        logic signed [CODE_BITS-1:0]     code;
        logic                            hasp;
        logic                            lst;
    } particle_req_t;

    typedef struct {
        logic [SUM_BITS-1:0] sum;
        logic                sat;
    } event_sum_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_wr_en     = 1'b0;
    logic                            cfg_wr_data   = 1'b0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic signed [MOMENTUM_BITS-1:0] mom_x         = '0;
    logic signed [MOMENTUM_BITS-1:0] mom_y         = '0;
    logic signed [MOMENTUM_BITS-1:0] mom_z         = '0;
    logic        [ENERGY_BITS-1:0]   energy        = '0;
    logic signed [CODE_BITS-1:0]     particle_code = '0;
    logic                            has_particle  = 1'b0;
    logic                            last          = 1'b0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic        [SUM_BITS-1:0]      ht_sum;
    logic                            sum_saturated;

    particle_req_t pending[$];
    event_sum_t    sum_expect[$];
    particle_req_t cur_req;

    bit     ht_mode_model = 1'b0;
    longint run_sum       = 0;
    bit     run_sat       = 1'b0;

    int reqs_queued      = 0;
    int reqs_accepted    = 0;
    int sums_checked     = 0;
    int sat_events       = 0;
    int mt_terms         = 0;
    int input_stall_cyc  = 0;
    int err_count        = 0;
    int burst_left       = 1;
    int gap_left         = 0;
    int stall_left       = 0;
    int stall_style      = 0;
    logic stall_pick;
    logic hold_off       = 1'b0;

    event_scalar_pt_sum_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mom_x         (mom_x),
        .mom_y         (mom_y),
        .mom_z         (mom_z),
        .energy        (energy),
        .particle_code (particle_code),
        .has_particle  (has_particle),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ht_sum        (ht_sum),
        .sum_saturated (sum_saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bit-by-bit floor square root
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = root | (longint'(1) << i);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic void fold_particle(particle_req_t r);
        longint     ax;
        longint     ay;
        longint     az;
        longint     en2;
        longint     term;
        longint     total;
        event_sum_t closed;
        if (r.hasp)
        begin
            ax = longint'(r.px);
            ay = longint'(r.py);
            az = longint'(r.pz);
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            if (az < 0) az = -az;
            if (ht_mode_model && $unsigned(r.code) == HIGGS_CODE)
            begin
                en2 = longint'(r.en) * longint'(r.en);
                term = (en2 > az * az) ? longint'(root_floor(en2 - az * az)) : 0;
                mt_terms++;
            end
            else
            begin
                term = longint'(root_floor(ax * ax + ay * ay));
            end
            total = run_sum + term;
            if (total >= longint'(SUM_MAX))
            begin
                total   = longint'(SUM_MAX);
                run_sat = 1'b1;
            end
            run_sum = total;
        end
        if (r.lst)
        begin
            closed.sum = run_sum[SUM_BITS-1:0];
            closed.sat = run_sat;
            sum_expect.push_back(closed);
            run_sum = 0;
            run_sat = 1'b0;
        end
    endfunction

    function automatic void push_req(logic signed [MOMENTUM_BITS-1:0] px,
                                     logic signed [MOMENTUM_BITS-1:0] py,
                                     logic signed [MOMENTUM_BITS-1:0] pz,
                                     logic [ENERGY_BITS-1:0] en,
                                     logic signed [CODE_BITS-1:0] code,
                                     logic hasp, logic lst);
        particle_req_t r;
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.en = en;
        r.code = code;
        r.hasp = hasp;
        r.lst = lst;
        pending.push_back(r);
        reqs_queued++;
    endfunction

    function automatic logic signed [MOMENTUM_BITS-1:0] rand_mom();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return MOMENTUM_BITS'($urandom);
        if (pick < 7)
            return MOMENTUM_BITS'($urandom_range(0, 8191) - 4096);
        if (pick < 9)
            return MOMENTUM_BITS'($urandom_range(0, 131071) - 65536);
        case ($urandom_range(0, 4))
            0: return MOM_MAX;
            1: return MOM_MIN;
            2: return '0;
            3: return '1;
            default: return MOMENTUM_BITS'(1);
        endcase
    endfunction

    function automatic logic [ENERGY_BITS-1:0] rand_energy();
        case ($urandom_range(0, 7))
            0, 1, 2: return ENERGY_BITS'($urandom);
            3, 4:    return ENERGY_BITS'($urandom_range(0, 8191));
            5:       return ENERGY_BITS'($urandom_range(0, 131071));
            6:       return EN_MAX;
            default: return ENERGY_BITS'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic signed [CODE_BITS-1:0] rand_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return HIGGS_CODE;
            4:          return CODE_BITS'($urandom);
            5:          return HIGGS_ALIAS;
            6:          return ANTI_HIGGS;
            7:          return ($urandom_range(0, 1) != 0) ? CODE_BITS'(HIGGS_CODE + 1)
                                                           : CODE_BITS'(HIGGS_CODE - 1);
            default:    return CODE_BITS'($urandom_range(0, 200) - 100);
        endcase
    endfunction

    function automatic int push_random_event();
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            push_req(rand_mom(), rand_mom(), rand_mom(), rand_energy(), rand_code(), 1'b0, 1'b1);
            return 1;
        end
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            push_req(rand_mom(), rand_mom(), rand_mom(), rand_energy(), rand_code(),
                     ($urandom_range(0, 9) != 0), (i == n - 1));
        return n;
    endfunction

    task automatic wait_idle();
        while (reqs_accepted != reqs_queued || sum_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        @(posedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= v;
        ht_mode_model = v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_stall)
                input_stall_cyc++;
            if (in_valid && !in_stall)
            begin
                fold_particle(cur_req);
                reqs_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    cur_req = pending.pop_front();
                    mom_x         <= cur_req.px;
                    mom_y         <= cur_req.py;
                    mom_z         <= cur_req.pz;
                    energy        <= cur_req.en;
                    particle_code <= cur_req.code;
                    has_particle  <= cur_req.hasp;
                    last          <= cur_req.lst;
                    in_valid      <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
        end
        else
        begin
            stall_left--;
        end
        case (stall_style)
            0:       stall_pick = 1'b0;
            1:       stall_pick = ($urandom_range(0, 1) != 0);
            2:       stall_pick = ($urandom_range(0, 3) == 0);
            default: stall_pick = stall_left[3];
        endcase
        out_stall <= hold_off || stall_pick;
    end

    // long output hold-offs to back the block up
    initial
    begin
        while (sums_checked < 40)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        while (sums_checked < 110)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sum_expect.size() == 0)
            begin
                $error("unexpected event sum: ht_sum %0d sum_saturated %0d",
                       ht_sum, sum_saturated);
                err_count++;
            end
            else
            begin
                if (ht_sum !== sum_expect[0].sum)
                begin
                    $error("ht_sum: expected %0d, actual %0d", sum_expect[0].sum, ht_sum);
                    err_count++;
                end
                if (sum_saturated !== sum_expect[0].sat)
                begin
                    $error("sum_saturated: expected %0d, actual %0d",
                           sum_expect[0].sat, sum_saturated);
                    err_count++;
                end
                if (sum_expect[0].sat)
                    sat_events++;
                sums_checked++;
                void'(sum_expect.pop_front());
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $error("timeout: %0d of %0d requests accepted, %0d sums outstanding",
               reqs_accepted, reqs_queued, sum_expect.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        longint unsigned diag;
        longint unsigned tail;
        int              n;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ht_mode at its reset value
        push_req(0, 0, 0, 0, 0, 1'b0, 1'b1);
        push_req(MOM_MAX, 0, MOM_MIN, EN_MAX, HIGGS_CODE, 1'b1, 1'b0);
        push_req(MOM_MIN, MOM_MIN, 0, 0, -1, 1'b1, 1'b1);
        push_req(0, 0, MOM_MAX, EN_MAX, HIGGS_CODE, 1'b1, 1'b1);
        push_req(MOM_MIN, MOM_MAX, MOM_MIN, EN_MAX, HIGGS_CODE, 1'b0, 1'b0);
        push_req(768, -1024, 0, 0, 11, 1'b1, 1'b1);
        push_req(-300, 400, 0, 1000, HIGGS_CODE, 1'b1, 1'b1);
        push_req(1, 1, 1, 1, 1, 1'b0, 1'b0);
        push_req(0, 0, 0, 0, 0, 1'b0, 1'b1);
        wait_idle();

        write_mode(1'b1);
        push_req(3, 4, -300, 500, HIGGS_CODE, 1'b1, 1'b1);
        push_req(0, 0, 200, 100, HIGGS_CODE, 1'b1, 1'b0);
        push_req(5, 5, -300, 300, HIGGS_CODE, 1'b1, 1'b1);
        push_req(0, 0, MOM_MIN, EN_MAX, HIGGS_CODE, 1'b1, 1'b0);
        push_req(0, 0, 0, EN_MAX, HIGGS_CODE, 1'b1, 1'b0);
        push_req(6, 8, 0, EN_MAX, ANTI_HIGGS, 1'b1, 1'b0);
        push_req(MOM_MAX, MOM_MAX, 0, 0, HIGGS_ALIAS, 1'b1, 1'b1);
        push_req(0, 0, 0, EN_MAX, HIGGS_CODE, 1'b0, 1'b1);
        push_req(1, 0, 0, 2, HIGGS_CODE, 1'b1, 1'b1);
        wait_idle();

        // one event landing exactly on the saturation value, then one more particle
        write_mode(1'b0);
        diag = root_floor(longint'(2) << (2 * (MOMENTUM_BITS - 1)));
        tail = longint'(SUM_MAX) - SAT_ITEMS * diag;
        for (int i = 0; i < SAT_ITEMS; i++)
            push_req(MOM_MIN, MOM_MIN, 0, 0, 0, 1'b1, 1'b0);
        push_req(MOMENTUM_BITS'(tail), 0, 0, 0, 0, 1'b1, 1'b0);
        push_req(100, 0, 0, 0, 0, 1'b1, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_mode((phase % 2) == 0);
            n = 0;
            while (n < RANDOM_ITEMS)
                n += push_random_event();
            wait_idle();
        end

        $display("%0d requests in both ht_mode settings, %0d event sums checked",
                 reqs_accepted, sums_checked);
        $display("%0d saturated events, %0d transverse-mass terms, input stalled %0d cycles",
                 sat_events, mt_terms, input_stall_cyc);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/espt_pkg.sv
hw/rtl/espt_front.sv
hw/rtl/espt_queue.sv
hw/rtl/espt_back.sv
hw/rtl/event_scalar_pt_sum_top.sv
bench/testbench.sv
